// File: rtl/stable_segment_throw_tracker_defines.svh
// Assertion macros used by the checker file of the throw tracker.
`ifndef STABLE_SEGMENT_THROW_TRACKER_DEFINES_SVH
`define STABLE_SEGMENT_THROW_TRACKER_DEFINES_SVH

// Concurrent assertion that is switched off while the reset is applied.
`define SSTT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion that is also checked while the reset is applied.
`define SSTT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sstt_pkg.sv
`timescale 1ns / 1ps

package sstt_pkg;

  localparam int unsigned SSTT_SAMPLE_BITS = 10;
  localparam int unsigned SSTT_TIME_BITS   = 32;

  // Width of the quotient of the distance fraction (Q1.15).
  localparam int unsigned SSTT_FRAC_BITS   = 16;

  localparam int unsigned SSTT_THRESH_RESET = 8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_FRONT     = 2'd1;
  localparam logic [1:0] CFG_BACK      = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } sstt_div_stat_t;

endpackage

// File: rtl/sstt_div.sv
`timescale 1ns / 1ps

// Bit-serial restoring divider for (dist * 2^15) / span, one quotient bit per cycle.
module sstt_div import sstt_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SSTT_SAMPLE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SAMPLE_BITS-1:0]    dist_i,
  input  logic [SAMPLE_BITS-1:0]    span_i,
  output logic [SSTT_FRAC_BITS-1:0] quot_o,
  output sstt_div_stat_t            stat_o
);

  localparam int unsigned CNT_W = $clog2(SSTT_FRAC_BITS);

  logic [SAMPLE_BITS-1:0]    rem_q, rem_d;
  logic [SAMPLE_BITS-1:0]    dvs_q, dvs_d;
  logic [SSTT_FRAC_BITS-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      lsb_q, lsb_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;

  logic [SAMPLE_BITS:0] trial;
  logic [SAMPLE_BITS:0] diff;
  logic                 ge;
  logic                 sat;

  // The quotient fits in 16 bits exactly when dist is below twice the span.
  assign sat   = {1'b0, dist_i} >= {span_i, 1'b0};
  assign trial = {rem_q, ((cnt_q == CNT_W'(SSTT_FRAC_BITS - 1)) ? lsb_q : 1'b0)};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    lsb_d  = lsb_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      if (span_i == '0) begin
        quot_d = '0;
        done_d = 1'b1;
      end else if (sat) begin
        quot_d = '1;
        done_d = 1'b1;
      end else begin
        // The upper dividend bits, dist >> 1, are already below the span.
        rem_d  = {1'b0, dist_i[SAMPLE_BITS-1:1]};
        lsb_d  = dist_i[0];
        dvs_d  = span_i;
        quot_d = '0;
        cnt_d  = CNT_W'(SSTT_FRAC_BITS - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d  = ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
      quot_d = {quot_q[SSTT_FRAC_BITS-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
    lsb_q  <= lsb_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: rtl/stable_segment_throw_tracker.sv
`timescale 1ns / 1ps

// Channel  | Direction | Payload (lowest bits first)
// s_axis   | in        | sample, time_stamp
// m_axis   | out       | is_stable, throw_done, throw_duration, distance_fraction, span_zero
// cfg      | in        | cfg_index_i selects threshold, front or back; cfg_data_i value
//
// A sample passes through these steps before the next s_axis transaction is taken:
// the state update, the load of the divider, the bit-serial quotient of the
// distance fraction, the hand-over and the output register.
// A zero span or a saturated fraction skips the bit-serial quotient.
// Reset is asynchronous, active low; all tracking state returns to its initial value.
// A stalled m_axis holds the finished result while the next sample is being tracked.
module stable_segment_throw_tracker import sstt_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SSTT_SAMPLE_BITS,
  parameter int unsigned TIME_BITS   = SSTT_TIME_BITS,
  localparam int unsigned IN_W  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((TIME_BITS + SSTT_FRAC_BITS + 3 + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_W-1:0]        s_axis_tdata,  // sample, time_stamp
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // is_stable, throw_done, throw_duration, distance_fraction, span_zero
  output logic [OUT_W-1:0]       m_axis_tdata,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [SAMPLE_BITS-1:0] cfg_data_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0] state_q, state_d;

  logic [SAMPLE_BITS-1:0] thr_q, front_q, back_q;

  logic [SAMPLE_BITS-1:0] prev_q, start_smp_q, end_smp_q;
  logic [TIME_BITS-1:0]   start_time_q, end_time_q;
  logic                   prev_stable_q, expect_start_q;
  logic                   stable_q, done_flag_q;
  logic [SSTT_FRAC_BITS-1:0] frac_q;

  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  logic                   in_fire;
  logic                   out_free;
  logic [SAMPLE_BITS-1:0] smp;
  logic [TIME_BITS-1:0]   tstamp;
  logic [SAMPLE_BITS-1:0] jump;
  logic                   stable;
  logic                   first_stable;
  logic [SAMPLE_BITS-1:0] throw_dist;
  logic [SAMPLE_BITS-1:0] span;
  logic                   div_start;
  logic [SSTT_FRAC_BITS-1:0] div_quot;
  sstt_div_stat_t         div_stat;
  logic [OUT_W-1:0]       out_word;

  assign smp    = s_axis_tdata[SAMPLE_BITS-1:0];
  assign tstamp = s_axis_tdata[SAMPLE_BITS +: TIME_BITS];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign jump         = (prev_q >= smp) ? (prev_q - smp) : (smp - prev_q);
  assign stable       = jump < thr_q;
  assign first_stable = stable && !prev_stable_q;

  assign throw_dist = (start_smp_q >= end_smp_q) ? (start_smp_q - end_smp_q)
                                                 : (end_smp_q - start_smp_q);
  assign span = (back_q >= front_q) ? (back_q - front_q) : (front_q - back_q);

  assign div_start = (state_q == ST_START);

  sstt_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dist_i (throw_dist),
    .span_i (span),
    .quot_o (div_quot),
    .stat_o (div_stat)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_START;
      ST_START: state_d = ST_WAIT;
      ST_WAIT:  if (div_stat.done) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_word = '0;
    out_word[0] = stable_q;
    out_word[1] = done_flag_q;
    out_word[2 +: TIME_BITS] = end_time_q - start_time_q;
    out_word[TIME_BITS + 2 +: SSTT_FRAC_BITS] = frac_q;
    out_word[TIME_BITS + SSTT_FRAC_BITS + 2] = (span == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      thr_q          <= SAMPLE_BITS'(SSTT_THRESH_RESET);
      front_q        <= '0;
      back_q         <= '1;
      prev_q         <= '0;
      prev_stable_q  <= 1'b0;
      expect_start_q <= 1'b1;
      start_smp_q    <= '0;
      start_time_q   <= '0;
      end_smp_q      <= '0;
      end_time_q     <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_THRESHOLD: thr_q   <= cfg_data_i;
          CFG_FRONT:     front_q <= cfg_data_i;
          CFG_BACK:      back_q  <= cfg_data_i;
          default:       ;
        endcase
      end

      if (in_fire) begin
        prev_q        <= smp;
        prev_stable_q <= stable;
        // The first stable sample of a run alternately marks the start and the end.
        if (first_stable) begin
          expect_start_q <= !expect_start_q;
          if (expect_start_q) begin
            start_smp_q  <= smp;
            start_time_q <= tstamp;
          end else begin
            end_smp_q  <= smp;
            end_time_q <= tstamp;
          end
        end
      end

      if (state_q == ST_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stable_q    <= stable;
      done_flag_q <= first_stable && !expect_start_q;
    end
    if (state_q == ST_WAIT && div_stat.done) begin
      frac_q <= div_quot;
    end
    if (state_q == ST_OUT && out_free) begin
      m_data_q <= out_word;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: rtl/sstt_checker.sv
`timescale 1ns / 1ps
`include "stable_segment_throw_tracker_defines.svh"

module sstt_checker import sstt_pkg::*; #(
  parameter int unsigned TIME_BITS   = SSTT_TIME_BITS,
  localparam int unsigned OUT_W = ((TIME_BITS + SSTT_FRAC_BITS + 3 + 7) / 8) * 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_W-1:0]       m_axis_tdata,
  input logic                   cfg_ready_o
);

  localparam int unsigned FRAC_LSB = TIME_BITS + 2;
  localparam int unsigned ZERO_BIT = TIME_BITS + SSTT_FRAC_BITS + 2;

  logic in_fire;
  logic done_bit;
  logic stable_bit;
  logic zero_bit;
  logic [SSTT_FRAC_BITS-1:0] frac_bits;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign stable_bit = m_axis_tdata[0];
  assign done_bit   = m_axis_tdata[1];
  assign frac_bits  = m_axis_tdata[FRAC_LSB +: SSTT_FRAC_BITS];
  assign zero_bit   = m_axis_tdata[ZERO_BIT];

  `SSTT_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `SSTT_ASSERT(a_done_stable, clk_i, rst_ni,
    m_axis_tvalid |-> (!done_bit || stable_bit), "throw end latched by an unstable sample")
  `SSTT_ASSERT(a_zero_frac, clk_i, rst_ni,
    m_axis_tvalid && zero_bit |-> (frac_bits == '0), "fraction not zero for a zero span")
  `SSTT_ASSERT(a_one_item, clk_i, rst_ni,
    in_fire |=> !s_axis_tready, "second sample taken while one is being tracked")
  `SSTT_ASSERT_ALWAYS(a_cfg_ready, clk_i,
    !rst_ni || cfg_ready_o, "configuration port not ready")

endmodule

bind stable_segment_throw_tracker sstt_checker #(
  .TIME_BITS  (TIME_BITS)
) u_sstt_checker (.*);
